[rtl/core/armc_pkg.sv]
`timescale 1ns / 1ps

package armc_pkg;

    localparam int CMD_W     = 3;
    localparam int HOUR_W    = 5;
    localparam int MINUTE_W  = 6;
    localparam int DIST_W    = 13;
    localparam int BYTE_W    = 8;
    localparam int SNOOZE_W  = 16;
    localparam int DUTY_W    = 9;
    localparam int MODE_W    = 3;
    localparam int FILL_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [DUTY_W-1:0] FULL_DUTY = DUTY_W'(256);

    typedef enum logic [MODE_W-1:0] {
        MODE_OFF    = 3'd0,
        MODE_ON     = 3'd1,
        MODE_SNOOZE = 3'd2,
        MODE_HAZARD = 3'd3,
        MODE_SHUT   = 3'd4
    } t_mode;

    typedef enum logic [CMD_W-1:0] {
        CMD_POLL   = 3'd0,
        CMD_DIST   = 3'd1,
        CMD_RX     = 3'd2,
        CMD_SECOND = 3'd3,
        CMD_MINUTE = 3'd4
    } t_cmd;

    typedef enum logic [FILL_W-1:0] {
        FILL_NONE  = 2'd0,
        FILL_RED   = 2'd1,
        FILL_BLACK = 2'd2
    } t_fill;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALARM_HOUR   = 3'd0,
        CFG_ALARM_MINUTE = 3'd1,
        CFG_HAZARD_MM    = 3'd2,
        CFG_SNOOZE_SEC   = 3'd3,
        CFG_CRUISE_DUTY  = 3'd4,
        CFG_TURN_DUTY    = 3'd5
    } t_cfg_idx;

    typedef enum logic [1:0] {
        RX_IDLE = 2'd0,
        RX_BANG = 2'd1,
        RX_ARG  = 2'd2
    } t_rx_phase;

    localparam logic [BYTE_W-1:0] CH_A    = 8'h61;
    localparam logic [BYTE_W-1:0] CH_B    = 8'h62;
    localparam logic [BYTE_W-1:0] CH_BANG = 8'h21;
    localparam logic [BYTE_W-1:0] CH_UB   = 8'h42;

    function automatic logic [DUTY_W-1:0] sat_duty(input logic [DUTY_W-1:0] d);
        return (d > FULL_DUTY) ? FULL_DUTY : d;
    endfunction

endpackage

[rtl/core/alarm_robot_mode_controller_core.sv]
`timescale 1ns / 1ps

// channel  | valid        | stall        | payload
// input    | i_in_valid   | o_in_stall   | i_cmd .. i_rx_byte
// output   | o_out_valid  | i_out_stall  | o_mode .. o_screen_fill
// config   | i_cfg_we     | none         | i_cfg_index, i_cfg_data
//
// one transaction per cycle unless an output stall holds the flow
// the mode update sits between the input register and the result register
// reset is synchronous: mode off, parser idle, snooze timer stopped
// an output stall holds the result and backs up into o_in_stall

module alarm_robot_mode_controller_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [armc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [armc_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [armc_pkg::CMD_W-1:0]         i_cmd,
    input  logic [armc_pkg::HOUR_W-1:0]        i_now_hour,
    input  logic [armc_pkg::MINUTE_W-1:0]      i_now_minute,
    input  logic                               i_off_pressed,
    input  logic                               i_snooze_pressed,
    input  logic [armc_pkg::DIST_W-1:0]        i_distance_mm,
    input  logic [armc_pkg::BYTE_W-1:0]        i_rx_byte,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [armc_pkg::MODE_W-1:0]        o_mode,
    output logic [armc_pkg::DUTY_W-1:0]        o_left_duty,
    output logic [armc_pkg::DUTY_W-1:0]        o_right_duty,
    output logic [armc_pkg::FILL_W-1:0]        o_screen_fill
);
    import armc_pkg::*;

    // config
    logic [HOUR_W-1:0]   r_alarm_hour;
    logic [MINUTE_W-1:0] r_alarm_minute;
    logic [DIST_W-1:0]   r_hazard_mm;
    logic [SNOOZE_W-1:0] r_snooze_sec;
    logic [DUTY_W-1:0]   r_cruise_duty;
    logic [DUTY_W-1:0]   r_turn_duty;

    // state
    t_mode               r_mode,         n_mode;
    logic                r_flash_black,  n_flash_black;
    logic [SNOOZE_W-1:0] r_snooze_left,  n_snooze_left;
    logic                r_snooze_run,   n_snooze_run;
    t_rx_phase           r_rx_phase,     n_rx_phase;

    // input register
    logic                r_s1_valid;
    logic [CMD_W-1:0]    r_s1_cmd;
    logic [HOUR_W-1:0]   r_s1_hour;
    logic [MINUTE_W-1:0] r_s1_minute;
    logic                r_s1_off;
    logic                r_s1_snz;
    logic [DIST_W-1:0]   r_s1_dist;
    logic [BYTE_W-1:0]   r_s1_rx;

    // result register
    logic                r_out_valid;
    logic [MODE_W-1:0]   r_out_mode;
    logic [DUTY_W-1:0]   r_out_left;
    logic [DUTY_W-1:0]   r_out_right;
    logic [FILL_W-1:0]   r_out_fill;

    logic                w_out_free;
    logic                w_adv;
    logic                w_in_acc;
    t_fill               w_fill;
    logic [DUTY_W-1:0]   w_left;
    logic [DUTY_W-1:0]   w_right;

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_adv      = r_s1_valid && w_out_free;
    assign o_in_stall = r_s1_valid && !w_out_free;
    assign w_in_acc   = i_in_valid && !o_in_stall;

    always_comb begin
        n_mode        = r_mode;
        n_flash_black = r_flash_black;
        n_snooze_left = r_snooze_left;
        n_snooze_run  = r_snooze_run;
        n_rx_phase    = r_rx_phase;
        w_fill        = FILL_NONE;
        unique case (r_s1_cmd)
            CMD_POLL: begin
                if (r_s1_hour == r_alarm_hour && r_s1_minute == r_alarm_minute &&
                    (n_mode == MODE_OFF || n_mode == MODE_ON)) begin
                    n_mode = MODE_ON;
                end
                if (n_mode == MODE_ON && r_s1_off) begin
                    n_mode = MODE_SHUT;
                end
                if (n_mode == MODE_ON && r_s1_snz) begin
                    n_mode        = MODE_SNOOZE;
                    n_snooze_left = r_snooze_sec;
                    n_snooze_run  = 1'b1;
                end
                if (n_mode == MODE_ON) begin
                    w_fill        = r_flash_black ? FILL_BLACK : FILL_RED;
                    n_flash_black = !r_flash_black;
                end else if (r_flash_black) begin
                    w_fill        = FILL_BLACK;
                    n_flash_black = 1'b0;
                end
            end
            CMD_DIST: begin
                if (r_s1_dist < r_hazard_mm && r_mode == MODE_ON) begin
                    n_mode = MODE_HAZARD;
                end else if (r_s1_dist >= r_hazard_mm && r_mode == MODE_HAZARD) begin
                    n_mode = MODE_ON;
                end
            end
            CMD_RX: begin
                if (r_rx_phase == RX_BANG) begin
                    n_rx_phase = (r_s1_rx == CH_UB) ? RX_ARG : RX_IDLE;
                end else if (r_rx_phase == RX_ARG) begin
                    n_mode        = MODE_SNOOZE;
                    n_snooze_left = r_snooze_sec;
                    n_snooze_run  = 1'b1;
                    n_rx_phase    = RX_IDLE;
                end else begin
                    n_rx_phase = RX_IDLE;
                    if (r_s1_rx == CH_A) begin
                        n_mode = MODE_ON;
                    end else if (r_s1_rx == CH_B) begin
                        n_mode = MODE_SHUT;
                    end else if (r_mode == MODE_ON && r_s1_rx == CH_BANG) begin
                        n_rx_phase = RX_BANG;
                    end
                end
            end
            CMD_SECOND: begin
                if (r_snooze_run) begin
                    if (r_snooze_left <= SNOOZE_W'(1)) begin
                        n_snooze_left = '0;
                        n_snooze_run  = 1'b0;
                        if (r_mode == MODE_SNOOZE) begin
                            n_mode = MODE_ON;
                        end
                    end else begin
                        n_snooze_left = r_snooze_left - SNOOZE_W'(1);
                    end
                end
            end
            CMD_MINUTE: begin
                if (r_mode == MODE_SHUT) begin
                    n_mode = MODE_OFF;
                end
            end
            default: begin
            end
        endcase

        w_left  = '0;
        w_right = '0;
        if (n_mode == MODE_ON) begin
            w_left  = sat_duty(r_cruise_duty);
            w_right = w_left;
        end else if (n_mode == MODE_HAZARD) begin
            w_left  = sat_duty(r_turn_duty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_hour   <= '0;
            r_alarm_minute <= '0;
            r_hazard_mm    <= DIST_W'(600);
            r_snooze_sec   <= SNOOZE_W'(60);
            r_cruise_duty  <= DUTY_W'(128);
            r_turn_duty    <= FULL_DUTY;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ALARM_HOUR:   r_alarm_hour   <= i_cfg_data[HOUR_W-1:0];
                CFG_ALARM_MINUTE: r_alarm_minute <= i_cfg_data[MINUTE_W-1:0];
                CFG_HAZARD_MM:    r_hazard_mm    <= i_cfg_data[DIST_W-1:0];
                CFG_SNOOZE_SEC:   r_snooze_sec   <= i_cfg_data[SNOOZE_W-1:0];
                CFG_CRUISE_DUTY:  r_cruise_duty  <= i_cfg_data[DUTY_W-1:0];
                CFG_TURN_DUTY:    r_turn_duty    <= i_cfg_data[DUTY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_OFF;
            r_flash_black <= 1'b0;
            r_snooze_left <= '0;
            r_snooze_run  <= 1'b0;
            r_rx_phase    <= RX_IDLE;
        end else if (w_adv) begin
            r_mode        <= n_mode;
            r_flash_black <= n_flash_black;
            r_snooze_left <= n_snooze_left;
            r_snooze_run  <= n_snooze_run;
            r_rx_phase    <= n_rx_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
        if (w_in_acc) begin
            r_s1_cmd    <= i_cmd;
            r_s1_hour   <= i_now_hour;
            r_s1_minute <= i_now_minute;
            r_s1_off    <= i_off_pressed;
            r_s1_snz    <= i_snooze_pressed;
            r_s1_dist   <= i_distance_mm;
            r_s1_rx     <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_s1_valid;
        end
        if (w_adv) begin
            r_out_mode  <= n_mode;
            r_out_left  <= w_left;
            r_out_right <= w_right;
            r_out_fill  <= w_fill;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_mode        = r_out_mode;
    assign o_left_duty   = r_out_left;
    assign o_right_duty  = r_out_right;
    assign o_screen_fill = r_out_fill;

endmodule

[rtl/core/armc_assert.sv]
`timescale 1ns / 1ps

module armc_assert (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [armc_pkg::MODE_W-1:0]    o_mode,
    input logic [armc_pkg::DUTY_W-1:0]    o_left_duty,
    input logic [armc_pkg::DUTY_W-1:0]    o_right_duty,
    input logic [armc_pkg::FILL_W-1:0]    o_screen_fill
);
    import armc_pkg::*;

    // stalled transaction holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_mode) &&
            $stable(o_left_duty) && $stable(o_right_duty) && $stable(o_screen_fill))
        else $error("output transaction changed while stalled");

    // mode on drives both wheels alike
    a_on_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mode == MODE_ON |->
            o_left_duty == o_right_duty && o_left_duty <= FULL_DUTY)
        else $error("wheel duties differ in mode on");

    // hazard turns in place on the left wheel
    a_hazard_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mode == MODE_HAZARD |->
            o_right_duty == '0 && o_left_duty <= FULL_DUTY)
        else $error("right wheel runs during hazard");

    // idle modes keep the wheels stopped
    a_stop_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_mode == MODE_OFF || o_mode == MODE_SNOOZE ||
            o_mode == MODE_SHUT) |-> o_left_duty == '0 && o_right_duty == '0)
        else $error("wheels run in a stopped mode");

    // red fill only while the alarm is on
    a_red_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_screen_fill == FILL_RED |-> o_mode == MODE_ON)
        else $error("red fill outside mode on");

endmodule

bind alarm_robot_mode_controller_core armc_assert u_armc_assert (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_mode        (o_mode),
    .o_left_duty   (o_left_duty),
    .o_right_duty  (o_right_duty),
    .o_screen_fill (o_screen_fill)
);

[test/alarm_mode_checker.sv]
`timescale 1ns / 1ps

module alarm_mode_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [armc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [armc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [armc_pkg::CMD_W-1:0]     i_cmd,
    input  logic [armc_pkg::HOUR_W-1:0]    i_now_hour,
    input  logic [armc_pkg::MINUTE_W-1:0]  i_now_minute,
    input  logic                           i_off_pressed,
    input  logic                           i_snooze_pressed,
    input  logic [armc_pkg::DIST_W-1:0]    i_distance_mm,
    input  logic [armc_pkg::BYTE_W-1:0]    i_rx_byte,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic [armc_pkg::MODE_W-1:0]    i_mode,
    input  logic [armc_pkg::DUTY_W-1:0]    i_left_duty,
    input  logic [armc_pkg::DUTY_W-1:0]    i_right_duty,
    input  logic [armc_pkg::FILL_W-1:0]    i_screen_fill,
    output int                             o_failures,
    output int                             o_waiting
);
    import armc_pkg::*;

    typedef struct {
        t_mode             mode;
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        t_fill             fill;
    } t_alarm_result;

    logic [HOUR_W-1:0]   wake_hour;
    logic [MINUTE_W-1:0] wake_minute;
    logic [DIST_W-1:0]   hazard_limit;
    logic [SNOOZE_W-1:0] snooze_len;
    logic [DUTY_W-1:0]   cruise_level;
    logic [DUTY_W-1:0]   turn_level;

    t_mode               mode_now;
    logic                black_pending;
    logic [SNOOZE_W-1:0] snooze_count;
    logic                snooze_active;
    t_rx_phase           rx_state;

    t_alarm_result       expected_results[$];
    t_alarm_result       want;
    t_alarm_result       next_result;
    int                  failures;
    logic                bad;

    task automatic start_snooze();
        mode_now = MODE_SNOOZE;
        snooze_count = snooze_len;
        snooze_active = 1'b1;
    endtask

    task automatic step_alarm(output t_alarm_result r);
        t_fill             fill;
        logic [DUTY_W-1:0] cruise;
        logic [DUTY_W-1:0] turn;
        fill = FILL_NONE;
        case (i_cmd)
            CMD_POLL: begin
                if (i_now_hour == wake_hour && i_now_minute == wake_minute &&
                    (mode_now == MODE_OFF || mode_now == MODE_ON))
                    mode_now = MODE_ON;
                if (mode_now == MODE_ON && i_off_pressed)
                    mode_now = MODE_SHUT;
                if (mode_now == MODE_ON && i_snooze_pressed)
                    start_snooze();
                if (mode_now == MODE_ON) begin
                    fill = black_pending ? FILL_BLACK : FILL_RED;
                    black_pending = !black_pending;
                end else if (black_pending) begin
                    fill = FILL_BLACK;
                    black_pending = 1'b0;
                end
            end
            CMD_DIST: begin
                if (i_distance_mm < hazard_limit && mode_now == MODE_ON)
                    mode_now = MODE_HAZARD;
                else if (i_distance_mm >= hazard_limit && mode_now == MODE_HAZARD)
                    mode_now = MODE_ON;
            end
            CMD_RX: begin
                case (rx_state)
                    RX_BANG: begin
                        rx_state = (i_rx_byte == CH_UB) ? RX_ARG : RX_IDLE;
                    end
                    RX_ARG: begin
                        // minutes byte is ignored, any value snoozes
                        start_snooze();
                        rx_state = RX_IDLE;
                    end
                    default: begin
                        rx_state = RX_IDLE;
                        if (i_rx_byte == CH_A)
                            mode_now = MODE_ON;
                        else if (i_rx_byte == CH_B)
                            mode_now = MODE_SHUT;
                        else if (mode_now == MODE_ON && i_rx_byte == CH_BANG)
                            rx_state = RX_BANG;
                    end
                endcase
            end
            CMD_SECOND: begin
                if (snooze_active) begin
                    if (snooze_count < SNOOZE_W'(2)) begin
                        snooze_count = '0;
                        snooze_active = 1'b0;
                        if (mode_now == MODE_SNOOZE)
                            mode_now = MODE_ON;
                    end else begin
                        snooze_count = snooze_count - 1'b1;
                    end
                end
            end
            CMD_MINUTE: begin
                if (mode_now == MODE_SHUT)
                    mode_now = MODE_OFF;
            end
            default: begin
            end
        endcase

        cruise = (cruise_level > FULL_DUTY) ? FULL_DUTY : cruise_level;
        turn = (turn_level > FULL_DUTY) ? FULL_DUTY : turn_level;
        r.mode = mode_now;
        r.fill = fill;
        r.left_duty = (mode_now == MODE_ON) ? cruise :
                      (mode_now == MODE_HAZARD) ? turn : '0;
        r.right_duty = (mode_now == MODE_ON) ? cruise : '0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            wake_hour = '0;
            wake_minute = '0;
            hazard_limit = DIST_W'(600);
            snooze_len = SNOOZE_W'(60);
            cruise_level = DUTY_W'(128);
            turn_level = DUTY_W'(256);
            mode_now = MODE_OFF;
            black_pending = 1'b0;
            snooze_count = '0;
            snooze_active = 1'b0;
            rx_state = RX_IDLE;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_ALARM_HOUR:   wake_hour = i_cfg_data[HOUR_W-1:0];
                    CFG_ALARM_MINUTE: wake_minute = i_cfg_data[MINUTE_W-1:0];
                    CFG_HAZARD_MM:    hazard_limit = i_cfg_data[DIST_W-1:0];
                    CFG_SNOOZE_SEC:   snooze_len = i_cfg_data[SNOOZE_W-1:0];
                    CFG_CRUISE_DUTY:  cruise_level = i_cfg_data[DUTY_W-1:0];
                    CFG_TURN_DUTY:    turn_level = i_cfg_data[DUTY_W-1:0];
                    default: begin
                    end
                endcase
            end

            if (i_out_valid && !i_out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("result transaction with nothing expected, mode %0d", i_mode);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    bad = 1'b0;
                    if (i_mode !== want.mode) begin
                        $error("mode expected %0d actual %0d", want.mode, i_mode);
                        bad = 1'b1;
                    end
                    if (i_left_duty !== want.left_duty) begin
                        $error("left_duty expected %0d actual %0d",
                               want.left_duty, i_left_duty);
                        bad = 1'b1;
                    end
                    if (i_right_duty !== want.right_duty) begin
                        $error("right_duty expected %0d actual %0d",
                               want.right_duty, i_right_duty);
                        bad = 1'b1;
                    end
                    if (i_screen_fill !== want.fill) begin
                        $error("screen_fill expected %0d actual %0d",
                               want.fill, i_screen_fill);
                        bad = 1'b1;
                    end
                    if (bad)
                        failures++;
                end
            end

            if (i_in_valid && !i_in_stall) begin
                step_alarm(next_result);
                expected_results.push_back(next_result);
            end
        end
        o_waiting <= expected_results.size();
        o_failures <= failures;
    end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import armc_pkg::*;

    localparam int LIMIT = 400000;
    localparam int RANDOM_EVENTS = 1330;
    localparam int PHASES = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [CMD_W-1:0]     cmd;
    logic [HOUR_W-1:0]    now_hour;
    logic [MINUTE_W-1:0]  now_minute;
    logic                 off_pressed;
    logic                 snooze_pressed;
    logic [DIST_W-1:0]    distance_mm;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic [MODE_W-1:0]    mode;
    logic [DUTY_W-1:0]    left_duty;
    logic [DUTY_W-1:0]    right_duty;
    logic [FILL_W-1:0]    screen_fill;

    int                   failures;
    int                   waiting;
    int                   cycles;
    int                   events_sent;
    bit                   sender_calm;
    bit                   sink_calm;
    logic [HOUR_W-1:0]    set_hour;
    logic [MINUTE_W-1:0]  set_minute;
    logic [DIST_W-1:0]    set_hazard;

    alarm_robot_mode_controller_core uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_cmd            (cmd),
        .i_now_hour       (now_hour),
        .i_now_minute     (now_minute),
        .i_off_pressed    (off_pressed),
        .i_snooze_pressed (snooze_pressed),
        .i_distance_mm    (distance_mm),
        .i_rx_byte        (rx_byte),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_mode           (mode),
        .o_left_duty      (left_duty),
        .o_right_duty     (right_duty),
        .o_screen_fill    (screen_fill)
    );

    alarm_mode_checker checker_inst (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_cmd            (cmd),
        .i_now_hour       (now_hour),
        .i_now_minute     (now_minute),
        .i_off_pressed    (off_pressed),
        .i_snooze_pressed (snooze_pressed),
        .i_distance_mm    (distance_mm),
        .i_rx_byte        (rx_byte),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_mode           (mode),
        .i_left_duty      (left_duty),
        .i_right_duty     (right_duty),
        .i_screen_fill    (screen_fill),
        .o_failures       (failures),
        .o_waiting        (waiting)
    );

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("alarm_robot_mode_controller_core test failed");
            $finish;
        end
    end

    task automatic send_event(input logic [CMD_W-1:0] c, input logic [HOUR_W-1:0] hr,
                              input logic [MINUTE_W-1:0] mn, input logic offp,
                              input logic snzp, input logic [DIST_W-1:0] dist_mm,
                              input logic [BYTE_W-1:0] b);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 14);
        @(negedge clk);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd = c;
        now_hour = hr;
        now_minute = mn;
        off_pressed = offp;
        snooze_pressed = snzp;
        distance_mm = dist_mm;
        rx_byte = b;
        in_valid = 1'b1;
        do @(posedge clk); while (in_stall);
        events_sent++;
    endtask

    // unused fields carry random values
    task automatic send_other(input logic [CMD_W-1:0] c, input logic [BYTE_W-1:0] b);
        send_event(c, HOUR_W'($urandom), MINUTE_W'($urandom), 1'($urandom),
                   1'($urandom), DIST_W'($urandom), b);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid = 1'b0;
        while (waiting != 0) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input int unsigned value,
                             input int width);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        // junk above the register width now and then
        if ($urandom_range(0, 3) == 0)
            cfg_data = CFG_W'(value | ($urandom << width));
        else
            cfg_data = CFG_W'(value);
    endtask

    task automatic program_settings(input int unsigned hr, input int unsigned mn,
                                    input int unsigned haz, input int unsigned snz,
                                    input int unsigned cruise, input int unsigned turn);
        set_hour = HOUR_W'(hr);
        set_minute = MINUTE_W'(mn);
        set_hazard = DIST_W'(haz);
        cfg_write(CFG_SPARE, $urandom, 0);
        cfg_write(CFG_ALARM_HOUR, hr, HOUR_W);
        cfg_write(CFG_ALARM_MINUTE, mn, MINUTE_W);
        cfg_write(CFG_HAZARD_MM, haz, DIST_W);
        cfg_write(CFG_SNOOZE_SEC, snz, SNOOZE_W);
        cfg_write(CFG_CRUISE_DUTY, cruise, DUTY_W);
        cfg_write(CFG_TURN_DUTY, turn, DUTY_W);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic random_event();
        int                  pick;
        int                  sub;
        int                  n;
        logic [HOUR_W-1:0]   hr;
        logic [MINUTE_W-1:0] mn;
        logic [DIST_W-1:0]   dist_mm;
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            if ($urandom_range(0, 2) == 0) begin
                hr = set_hour;
                mn = set_minute;
            end else begin
                hr = HOUR_W'($urandom_range(0, 23));
                mn = MINUTE_W'($urandom_range(0, 59));
            end
            send_event(CMD_POLL, hr, mn, $urandom_range(0, 6) == 0,
                       $urandom_range(0, 4) == 0, DIST_W'($urandom), BYTE_W'($urandom));
        end else if (pick < 45) begin
            case ($urandom_range(0, 3))
                0:       dist_mm = set_hazard - 1'b1;
                1:       dist_mm = set_hazard;
                2:       dist_mm = DIST_W'($urandom_range(0, 2 * set_hazard));
                default: dist_mm = DIST_W'($urandom);
            endcase
            send_event(CMD_DIST, HOUR_W'($urandom), MINUTE_W'($urandom), 1'($urandom),
                       1'($urandom), dist_mm, BYTE_W'($urandom));
        end else if (pick < 70) begin
            sub = $urandom_range(0, 9);
            if (sub < 4) begin
                // bang, B, minutes byte; sometimes a broken second byte
                if (sub == 0)
                    send_other(CMD_RX, CH_A);
                send_other(CMD_RX, CH_BANG);
                send_other(CMD_RX, (sub == 3) ? BYTE_W'($urandom) : CH_UB);
                send_other(CMD_RX, BYTE_W'($urandom));
            end else if (sub < 6) begin
                send_other(CMD_RX, CH_A);
            end else if (sub == 6) begin
                send_other(CMD_RX, CH_B);
            end else if (sub == 7) begin
                send_other(CMD_RX, CH_BANG);
                send_other(CMD_RX, BYTE_W'($urandom));
            end else begin
                send_other(CMD_RX, BYTE_W'($urandom));
            end
        end else if (pick < 88) begin
            n = $urandom_range(1, 4);
            repeat (n) send_other(CMD_SECOND, BYTE_W'($urandom));
        end else if (pick < 96) begin
            send_other(CMD_MINUTE, BYTE_W'($urandom));
        end else begin
            send_other(CMD_W'($urandom_range(CMD_MINUTE + 1, (1 << CMD_W) - 1)),
                       BYTE_W'($urandom));
        end
    endtask

    initial begin
        int hold;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            hold = sink_calm ? 0 : $urandom_range(0, 14);
            repeat (hold) begin
                @(negedge clk);
                out_stall = 1'b1;
            end
            @(negedge clk);
            out_stall = 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        int phase;
        int target;
        int half;
        bit paused;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        cmd = CMD_POLL;
        now_hour = '0;
        now_minute = '0;
        off_pressed = 1'b0;
        snooze_pressed = 1'b0;
        distance_mm = '0;
        rx_byte = '0;
        sender_calm = 1'b0;
        sink_calm = 1'b0;
        events_sent = 0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        program_settings(7, 30, 600, 2, 256, 300);
        send_event(CMD_POLL, 0, 0, 1'b0, 1'b0, 0, 0);
        send_event(CMD_MINUTE, 0, 0, 1'b0, 1'b0, 0, 0);
        send_event(CMD_POLL, 7, 30, 1'b0, 1'b0, 0, 0);
        send_event(CMD_POLL, 31, 63, 1'b0, 1'b0, 0, 0);
        send_event(CMD_DIST, 0, 0, 1'b0, 1'b0, 599, 0);
        send_event(CMD_DIST, 0, 0, 1'b0, 1'b0, 600, 0);
        send_event(CMD_DIST, 0, 0, 1'b0, 1'b0, 0, 0);
        send_event(CMD_DIST, 0, 0, 1'b0, 1'b0, 8191, 0);
        send_event(CMD_POLL, 7, 30, 1'b0, 1'b1, 0, 0);
        send_event(CMD_SECOND, 0, 0, 1'b0, 1'b0, 0, 0);
        send_event(CMD_SECOND, 0, 0, 1'b0, 1'b0, 0, 0);
        send_event(CMD_SECOND, 0, 0, 1'b0, 1'b0, 0, 0);
        send_event(CMD_POLL, 12, 0, 1'b1, 1'b0, 0, 0);
        send_event(CMD_MINUTE, 0, 0, 1'b0, 1'b0, 0, 0);
        send_event(CMD_RX, 0, 0, 1'b0, 1'b0, 0, CH_A);
        send_event(CMD_RX, 0, 0, 1'b0, 1'b0, 0, CH_BANG);
        send_event(CMD_RX, 0, 0, 1'b0, 1'b0, 0, CH_UB);
        send_event(CMD_RX, 0, 0, 1'b0, 1'b0, 0, 8'hFF);
        send_event(CMD_RX, 0, 0, 1'b0, 1'b0, 0, CH_B);
        send_event(CMD_RX, 0, 0, 1'b0, 1'b0, 0, CH_A);
        send_event(CMD_RX, 0, 0, 1'b0, 1'b0, 0, CH_BANG);
        send_event(CMD_RX, 0, 0, 1'b0, 1'b0, 0, 8'h00);
        send_event(CMD_RX, 0, 0, 1'b0, 1'b0, 0, CH_UB);
        send_event(CMD_W'(CMD_MINUTE + 1), 0, 0, 1'b0, 1'b0, 0, 0);
        send_event(CMD_POLL, 23, 59, 1'b1, 1'b1, 8191, 8'hFF);

        half = RANDOM_EVENTS / (2 * PHASES);
        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            case (phase)
                0: program_settings(0, 0, 0, 0, 0, 0);
                1: program_settings(23, 59, 8191, 65535, 511, 256);
                default: program_settings($urandom_range(0, 23), $urandom_range(0, 59),
                                          $urandom_range(0, 8191),
                                          ($urandom_range(0, 4) == 0) ?
                                              $urandom_range(0, 65535) :
                                              $urandom_range(1, 8),
                                          $urandom_range(0, 511), $urandom_range(0, 511));
            endcase
            sender_calm = (phase % 4 == 1) || (phase % 4 == 2);
            sink_calm = (phase % 4 == 1) || (phase % 4 == 3);
            target = events_sent + RANDOM_EVENTS / PHASES;
            paused = 1'b0;
            while (events_sent < target) begin
                if (!paused && events_sent >= target - half) begin
                    wait_idle();
                    paused = 1'b1;
                end
                random_event();
            end
        end

        wait_idle();
        repeat (8) @(negedge clk);
        if (failures == 0 && waiting == 0)
            $display("alarm_robot_mode_controller_core test passed");
        else
            $display("alarm_robot_mode_controller_core test failed");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/armc_pkg.sv
rtl/core/alarm_robot_mode_controller_core.sv
rtl/core/armc_assert.sv
test/alarm_mode_checker.sv
test/testbench.sv
